[rtl/tfpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tfpt_pkg;

  localparam int ADDR_W = 16;
  localparam int PAGE_W = 8;
  localparam int OFFSET_W = 8;
  localparam int PHYS_W = 15;
  localparam int PAGE_COUNT = 256;

  localparam int TLB_ENTRIES_DEFAULT = 16;
  localparam int FRAME_COUNT_DEFAULT = 128;
  localparam int PAGE_BYTES_DEFAULT = 256;

  // TLB maintenance requested by the translator for one item.
  typedef struct packed {
    logic              write;
    logic              drop;
    logic [PAGE_W-1:0] drop_page;
  } tlb_update_t;

endpackage

`default_nettype wire

[rtl/tlb_fifo_page_translator.sv]
`timescale 1ns / 1ps
`default_nettype none

// A new item is accepted only in S_IDLE, after the last one has left S_LOOK. The accept cycle
// reads the page map and the frame owner map; S_LOOK does the TLB compare and, once the output is
// free, the page-map/TLB update, and writes the result into the output register.
// A stalled output holds the translator in S_LOOK and stalls the input.
// Reset clears the TLB valid bits, residency bits and all pointers;
// no memory clearing pass is needed.
module tlb_fifo_page_translator #(
  parameter int TLB_ENTRIES = tfpt_pkg::TLB_ENTRIES_DEFAULT,
  parameter int FRAME_COUNT = tfpt_pkg::FRAME_COUNT_DEFAULT,
  parameter int PAGE_BYTES = tfpt_pkg::PAGE_BYTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tfpt_pkg::ADDR_W-1:0] vaddr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tfpt_pkg::PHYS_W-1:0] paddr,
  output logic                        tlb_hit,
  output logic                        page_fault
);

  import tfpt_pkg::*;

  localparam int FRAME_W = $clog2(FRAME_COUNT);

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state;

  logic [PAGE_W-1:0]     page;
  logic [OFFSET_W-1:0]   offset;
  logic [PAGE_COUNT-1:0] resident;
  logic [PAGE_COUNT-1:0] resident_next;
  logic [FRAME_W-1:0]    next_victim_frame;
  logic                  frames_all_used;

  logic                accept;
  logic                step;
  logic                out_free;
  logic                page_is_resident;
  logic                miss;
  logic                fault;
  logic                map_update;
  logic                hit_w;
  logic [FRAME_W-1:0]  hit_frame;
  logic [FRAME_W-1:0]  map_frame;
  logic [PAGE_W-1:0]   owner_page;
  logic [FRAME_W-1:0]  frame_sel;
  logic [31:0]         phys_sum;
  logic [PHYS_W-1:0]   paddr_next;
  tlb_update_t         update;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign step = (state == S_LOOK) && out_free;

  assign page_is_resident = resident[page];
  assign miss = !hit_w;
  assign fault = miss && !page_is_resident;
  assign map_update = step && fault;

  always_comb begin
    if (hit_w) begin
      frame_sel = hit_frame;
    end else if (page_is_resident) begin
      frame_sel = map_frame;
    end else begin
      frame_sel = next_victim_frame;
    end
  end

  assign phys_sum = 32'(frame_sel) * 32'(PAGE_BYTES) + 32'(offset);
  assign paddr_next = phys_sum[PHYS_W-1:0];

  // The victim page loses residency before the faulting page gains it.
  always_comb begin
    resident_next = resident;
    if (map_update) begin
      if (frames_all_used) begin
        resident_next[owner_page] = 1'b0;
      end
      resident_next[page] = 1'b1;
    end
  end

  assign update.write = step && miss;
  assign update.drop = map_update && frames_all_used;
  assign update.drop_page = owner_page;

  tfpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .FRAME_W(FRAME_W)
  ) u_tlb (
    .clk(clk),
    .rst(rst),
    .page(page),
    .update(update),
    .write_frame(frame_sel),
    .hit(hit_w),
    .hit_frame(hit_frame)
  );

  // Page number to frame map.
  tfpt_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(PAGE_COUNT)
  ) u_page_frame (
    .clk(clk),
    .we(map_update),
    .waddr(page),
    .wdata(next_victim_frame),
    .re(accept),
    .raddr(vaddr[ADDR_W-1:OFFSET_W]),
    .rdata(map_frame)
  );

  // Frame to owning page map; read ahead at the victim frame for a possible eviction.
  tfpt_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(FRAME_COUNT)
  ) u_frame_owner (
    .clk(clk),
    .we(map_update),
    .waddr(next_victim_frame),
    .wdata(page),
    .re(accept),
    .raddr(next_victim_frame),
    .rdata(owner_page)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      resident <= '0;
      next_victim_frame <= '0;
      frames_all_used <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (step) begin
        out_valid <= 1'b1;
        paddr <= paddr_next;
        tlb_hit <= hit_w;
        page_fault <= fault;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      resident <= resident_next;
      if (map_update) begin
        if (next_victim_frame == FRAME_W'(FRAME_COUNT - 1)) begin
          next_victim_frame <= '0;
          frames_all_used <= 1'b1;
        end else begin
          next_victim_frame <= next_victim_frame + FRAME_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page <= vaddr[ADDR_W-1:OFFSET_W];
      offset <= vaddr[OFFSET_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/tfpt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/tfpt_tlb.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpt_tlb #(
  parameter int TLB_ENTRIES = 16,
  parameter int FRAME_W = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tfpt_pkg::PAGE_W-1:0] page,
  input  tfpt_pkg::tlb_update_t       update,
  input  logic [FRAME_W-1:0]          write_frame,
  output logic                        hit,
  output logic [FRAME_W-1:0]          hit_frame
);

  import tfpt_pkg::*;

  localparam int PTR_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  logic [PAGE_W-1:0]  entry_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0] entry_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;
  logic [TLB_ENTRIES-1:0] valid_next;
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] write_pointer_next;

  // Walk from the top down so that the lowest matching entry wins.
  always_comb begin
    hit = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && entry_page[i] == page) begin
        hit = 1'b1;
        hit_frame = entry_frame[i];
      end
    end
  end

  // The evicted page is dropped first; the new entry is then set valid.
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      valid_next[i] = valid[i] &&
                      !(update.drop && entry_page[i] == update.drop_page);
      if (update.write && write_pointer == PTR_W'(i)) begin
        valid_next[i] = 1'b1;
      end
    end
  end

  always_comb begin
    if (write_pointer == PTR_W'(TLB_ENTRIES - 1)) begin
      write_pointer_next = '0;
    end else begin
      write_pointer_next = write_pointer + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      write_pointer <= '0;
    end else begin
      valid <= valid_next;
      if (update.write) begin
        write_pointer <= write_pointer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update.write) begin
      entry_page[write_pointer] <= page;
      entry_frame[write_pointer] <= write_frame;
    end
  end

endmodule

`default_nettype wire
